// ===== hw/rtl/srbas_pkg.sv =====
// ----------------------------------------------------------------------------
// srbas_pkg
// Shared types and constants for the socket ring buffer address split.
// ----------------------------------------------------------------------------
package srbas_pkg;

  localparam int PTR_W  = 16;
  localparam int LEN_W  = 14;
  localparam int SIZE_W = 14;
  localparam int OFFS_W = 13;
  localparam int END_W  = 15;
  localparam int SUM_W  = 16;
  localparam int CODE_W = 2;
  localparam int SOCK_W = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 8;

  localparam int MAX_SOCKETS  = 4;
  localparam int SOCKET_COUNT = 4;

  localparam logic [PTR_W-1:0]  TX_POOL_BASE = 16'h4000;
  localparam logic [PTR_W-1:0]  RX_POOL_BASE = 16'h6000;
  localparam logic [SUM_W-1:0]  POOL_BYTES   = 16'h2000;
  localparam logic [SIZE_W-1:0] MIN_CH_SIZE  = 14'h0400;

  localparam logic [CFG_W-1:0]  CODES_RESET  = 8'h55;

  typedef enum logic {
    REG_TX_CODES = 1'b0,
    REG_RX_CODES = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // Channel lookup stage -> offset stage
  typedef struct packed {
    logic              valid;
    logic [PTR_W-1:0]  ptr;
    logic [LEN_W-1:0]  len;
    logic [SIZE_W-1:0] size;
    logic [PTR_W-1:0]  base;
  } chan_beat_t;

  // Offset stage -> length stage
  typedef struct packed {
    logic              valid;
    logic [PTR_W-1:0]  ptr;
    logic [LEN_W-1:0]  len;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] offset;
    logic [END_W-1:0]  seg_end;
    logic [PTR_W-1:0]  base;
    logic [PTR_W-1:0]  first_addr;
    logic [PTR_W-1:0]  next_ptr;
    logic              zero;
    logic              over;
  } offs_beat_t;

endpackage

// ===== hw/rtl/srbas_chan_stage.sv =====
// ----------------------------------------------------------------------------
// srbas_chan_stage
// Resolves channel size and base from the size codes, registers the beat.
// ----------------------------------------------------------------------------
module srbas_chan_stage import srbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               in_req_type,
  input  logic [SOCK_W-1:0]  in_socket_index,
  input  logic [PTR_W-1:0]   in_ring_pointer,
  input  logic [LEN_W-1:0]   in_transfer_length,
  input  logic [CFG_W-1:0]   tx_codes,
  input  logic [CFG_W-1:0]   rx_codes,
  output chan_beat_t         beat_o
);

  chan_beat_t        beat_r;
  chan_beat_t        beat_nxt;
  logic [CFG_W-1:0]  codes;
  logic [SUM_W-1:0]  sum;
  logic [PTR_W-1:0]  run_base;
  logic [SIZE_W-1:0] step_sz;
  logic [SIZE_W-1:0] ch_size;
  logic              found;

  // Prefix walk over at most four sockets; base stops advancing once found.
  always_comb begin
    codes    = in_req_type ? rx_codes : tx_codes;
    run_base = in_req_type ? RX_POOL_BASE : TX_POOL_BASE;
    sum      = '0;
    ch_size  = '0;
    found    = 1'b0;
    step_sz  = '0;
    for (int i = 0; i < MAX_SOCKETS; i++) begin
      if ((i < SOCKET_COUNT) && !found) begin
        step_sz = '0;
        if (sum < POOL_BYTES) begin
          step_sz = MIN_CH_SIZE << codes[CODE_W*i +: CODE_W];
        end
        if (in_socket_index == SOCK_W'(i)) begin
          ch_size = step_sz;
          found   = 1'b1;
        end else begin
          sum      = sum + SUM_W'(step_sz);
          run_base = run_base + PTR_W'(step_sz);
        end
      end
    end
  end

  always_comb begin
    beat_nxt.valid = take;
    beat_nxt.ptr   = in_ring_pointer;
    beat_nxt.len   = in_transfer_length;
    beat_nxt.size  = ch_size;
    beat_nxt.base  = run_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.ptr  <= beat_nxt.ptr;
    beat_r.len  <= beat_nxt.len;
    beat_r.size <= beat_nxt.size;
    beat_r.base <= beat_nxt.base;
  end

  assign beat_o = beat_r;

endmodule

// ===== hw/rtl/srbas_offs_stage.sv =====
// ----------------------------------------------------------------------------
// srbas_offs_stage
// Masks the pointer into the channel, forms start address and segment end.
// ----------------------------------------------------------------------------
module srbas_offs_stage import srbas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chan_beat_t  beat_i,
  output offs_beat_t  beat_o
);

  offs_beat_t        beat_r;
  offs_beat_t        beat_nxt;
  logic [OFFS_W-1:0] mask;

  always_comb begin
    mask = (beat_i.size == '0) ? '0 : OFFS_W'(beat_i.size - SIZE_W'(1));
    beat_nxt.valid      = beat_i.valid;
    beat_nxt.ptr        = beat_i.ptr;
    beat_nxt.len        = beat_i.len;
    beat_nxt.size       = beat_i.size;
    beat_nxt.offset     = beat_i.ptr[OFFS_W-1:0] & mask;
    beat_nxt.seg_end    = END_W'(beat_i.len) + END_W'(beat_nxt.offset);
    beat_nxt.base       = beat_i.base;
    beat_nxt.first_addr = beat_i.base + PTR_W'(beat_nxt.offset);
    beat_nxt.next_ptr   = beat_i.ptr + PTR_W'(beat_i.len);
    beat_nxt.zero       = (beat_i.size == '0);
    beat_nxt.over       = (beat_i.len > beat_i.size);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.ptr        <= beat_nxt.ptr;
    beat_r.len        <= beat_nxt.len;
    beat_r.size       <= beat_nxt.size;
    beat_r.offset     <= beat_nxt.offset;
    beat_r.seg_end    <= beat_nxt.seg_end;
    beat_r.base       <= beat_nxt.base;
    beat_r.first_addr <= beat_nxt.first_addr;
    beat_r.next_ptr   <= beat_nxt.next_ptr;
    beat_r.zero       <= beat_nxt.zero;
    beat_r.over       <= beat_nxt.over;
  end

  assign beat_o = beat_r;

endmodule

// ===== hw/rtl/srbas_len_stage.sv =====
// ----------------------------------------------------------------------------
// srbas_len_stage
// Splits the length at the channel end, sets status, registers the result.
// ----------------------------------------------------------------------------
module srbas_len_stage import srbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  offs_beat_t         beat_i,
  output logic               out_valid,
  output logic [PTR_W-1:0]   out_first_address,
  output logic [LEN_W-1:0]   out_first_length,
  output logic [PTR_W-1:0]   out_second_address,
  output logic [LEN_W-1:0]   out_second_length,
  output logic [PTR_W-1:0]   out_next_pointer,
  output logic [STAT_W-1:0]  out_status
);

  logic              valid_r;
  logic [PTR_W-1:0]  first_addr_r;
  logic [LEN_W-1:0]  first_len_r,  first_len_nxt;
  logic [PTR_W-1:0]  second_addr_r;
  logic [LEN_W-1:0]  second_len_r, second_len_nxt;
  logic [PTR_W-1:0]  next_ptr_r,   next_ptr_nxt;
  status_t           status_r,     status_nxt;

  always_comb begin
    first_len_nxt  = '0;
    second_len_nxt = '0;
    next_ptr_nxt   = beat_i.ptr;
    status_nxt     = ST_OK;
    if (beat_i.zero) begin
      status_nxt = ST_NO_MEM;
    end else if (beat_i.over) begin
      status_nxt = ST_TOO_LONG;
    end else begin
      next_ptr_nxt = beat_i.next_ptr;
      if (beat_i.seg_end > END_W'(beat_i.size)) begin
        first_len_nxt  = beat_i.size - SIZE_W'(beat_i.offset);
        second_len_nxt = LEN_W'(beat_i.seg_end - END_W'(beat_i.size));
      end else begin
        first_len_nxt  = beat_i.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= beat_i.valid;
    end
    first_addr_r  <= beat_i.first_addr;
    first_len_r   <= first_len_nxt;
    second_addr_r <= beat_i.base;
    second_len_r  <= second_len_nxt;
    next_ptr_r    <= next_ptr_nxt;
    status_r      <= status_nxt;
  end

  assign out_valid          = valid_r;
  assign out_first_address  = first_addr_r;
  assign out_first_length   = first_len_r;
  assign out_second_address = second_addr_r;
  assign out_second_length  = second_len_r;
  assign out_next_pointer   = next_ptr_r;
  assign out_status         = status_r;

endmodule

// ===== hw/rtl/socket_ring_buffer_address_split_top.sv =====
// Pipeline: an accepted beat passes three register stages (channel, offset,
// length split) and then shows out_valid for one cycle.
// Throughput: one beat per cycle; busy is never raised, results cannot stall.
// Reset (synchronous, rst_n low): stage valids clear, size codes return to 0x55.
// ----------------------------------------------------------------------------
// socket_ring_buffer_address_split_top
// Maps socket ring pointers to physical buffer segments with wrap split.
// ----------------------------------------------------------------------------
module socket_ring_buffer_address_split_top import srbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [SOCK_W-1:0]  in_socket_index,
  input  logic [PTR_W-1:0]   in_ring_pointer,
  input  logic [LEN_W-1:0]   in_transfer_length,
  output logic               out_valid,
  output logic [PTR_W-1:0]   out_first_address,
  output logic [LEN_W-1:0]   out_first_length,
  output logic [PTR_W-1:0]   out_second_address,
  output logic [LEN_W-1:0]   out_second_length,
  output logic [PTR_W-1:0]   out_next_pointer,
  output logic [STAT_W-1:0]  out_status
);

  logic [CFG_W-1:0] tx_codes_r;
  logic [CFG_W-1:0] rx_codes_r;
  chan_beat_t       chan_beat;
  offs_beat_t       offs_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_codes_r <= CODES_RESET;
      rx_codes_r <= CODES_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TX_CODES: tx_codes_r <= cfg_wdata;
        REG_RX_CODES: rx_codes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  srbas_chan_stage u_chan (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (start && !busy),
    .in_req_type        (in_req_type),
    .in_socket_index    (in_socket_index),
    .in_ring_pointer    (in_ring_pointer),
    .in_transfer_length (in_transfer_length),
    .tx_codes           (tx_codes_r),
    .rx_codes           (rx_codes_r),
    .beat_o             (chan_beat)
  );

  srbas_offs_stage u_offs (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (chan_beat),
    .beat_o (offs_beat)
  );

  srbas_len_stage u_len (
    .clk                (clk),
    .rst_n              (rst_n),
    .beat_i             (offs_beat),
    .out_valid          (out_valid),
    .out_first_address  (out_first_address),
    .out_first_length   (out_first_length),
    .out_second_address (out_second_address),
    .out_second_length  (out_second_length),
    .out_next_pointer   (out_next_pointer),
    .out_status         (out_status)
  );

endmodule

// ===== hw/rtl/srbas_checker.sv =====
// ----------------------------------------------------------------------------
// srbas_checker
// Port-level checks on beat timing and result consistency.
// ----------------------------------------------------------------------------
module srbas_checker import srbas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               out_valid,
  input  logic [PTR_W-1:0]   out_first_address,
  input  logic [LEN_W-1:0]   out_first_length,
  input  logic [PTR_W-1:0]   out_second_address,
  input  logic [LEN_W-1:0]   out_second_length,
  input  logic [STAT_W-1:0]  out_status
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without accepted beat");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_MEM || out_status == ST_TOO_LONG)) |->
      (out_first_length == '0 && out_second_length == '0))
    else $error("error result carries length");

  a_nomem_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_MEM) |->
      (out_first_address == out_second_address))
    else $error("empty channel address mismatch");

endmodule

bind socket_ring_buffer_address_split_top srbas_checker u_srbas_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_first_address  (out_first_address),
  .out_first_length   (out_first_length),
  .out_second_address (out_second_address),
  .out_second_length  (out_second_length),
  .out_status         (out_status)
);
